/* hw/rtl/obsp_pkg.sv */
`default_nettype none

package obsp_pkg;

	// width of the row width limit register
	localparam int LIMIT_BITS = 16;

	// row width limit after reset
	localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1);

endpackage

`default_nettype wire

/* hw/rtl/oriented_box_shelf_placer.sv */
`default_nettype none

// Oriented box shelf placer. Cells of a piece arrive one beat at a time; the
// beat with last_cell high closes the piece and yields one result beat, other
// beats yield none. The piece is turned 90 degrees clockwise when its y extent
// is smaller than its x extent (never mirrored) and its box is placed next-fit
// on shelves, wrapping when it would pass row_width_limit on a non-empty shelf,
// with cursors saturating at 2^CURSOR_BITS-1. Throughput is one cell per clock
// while in_stall is low; a last cell passes through the input register, box
// register and result register before out_valid rises. The extent fold sits
// between the input and box registers and the shelf placement between the box
// and result registers. Input is held off only while the input register holds
// a last cell, the box register holds a piece and the full result register is
// stalled. Write row_width_limit only while the block is idle.
module oriented_box_shelf_placer #(
	parameter int COORD_BITS  = 12,
	parameter int CURSOR_BITS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic        [obsp_pkg::LIMIT_BITS-1:0] row_width_limit,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [COORD_BITS-1:0]           cell_x,
	input  wire logic signed [COORD_BITS-1:0]           cell_y,
	input  wire logic                                   last_cell,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed      [CURSOR_BITS+1:0]          shift_x,
	output logic signed      [CURSOR_BITS+1:0]          shift_y,
	output logic                                        rotation,
	output logic                                        mirrored,
	output logic             [COORD_BITS:0]             box_width,
	output logic             [COORD_BITS:0]             box_height,
	output logic             [2*COORD_BITS:0]           box_area,
	output logic             [CURSOR_BITS-1:0]          square_side
);

	localparam int C  = COORD_BITS;
	localparam int K  = CURSOR_BITS;
	localparam int BW = C + 1;
	localparam int AW = 2 * C + 1;

	logic [obsp_pkg::LIMIT_BITS-1:0] limit_q;

	logic                v_s1, last_s1;
	logic signed [C-1:0] cx_s1, cy_s1;

	logic                v_s2, rot_s2;
	logic [BW-1:0]       w_s2, h_s2;
	logic signed [C:0]   ox_s2, oy_s2;

	logic                out_valid_q, rot_q;
	logic signed [K+1:0] shift_x_q, shift_y_q;
	logic [BW-1:0]       w_q, h_q;
	logic [AW-1:0]       area_q;
	logic [K-1:0]        side_q;

	logic adv_out, adv2, adv1, s1_step, commit;

	logic                rot_c;
	logic [BW-1:0]       w_c, h_c;
	logic signed [C:0]   ox_c, oy_c;
	logic signed [K+1:0] sx_c, sy_c;
	logic [K-1:0]        side_c;
	logic [2*BW-1:0]     prod;

	// each stage moves when the next one is free or moving, the input register also when it holds no last cell
	assign adv_out  = !out_valid_q || !out_stall;
	assign adv2     = !v_s2 || adv_out;
	assign adv1     = !v_s1 || !last_s1 || adv2;
	assign in_stall = !adv1;
	assign s1_step  = v_s1 && adv1;
	assign commit   = v_s2 && adv_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= obsp_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= row_width_limit;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv1) begin
			cx_s1   <= cell_x;
			cy_s1   <= cell_y;
			last_s1 <= last_cell;
		end
	end

	obsp_extent #(
		.COORD_BITS(C)
	) u_extent (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (s1_step),
		.last  (last_s1),
		.cell_x(cx_s1),
		.cell_y(cy_s1),
		.rot   (rot_c),
		.box_w (w_c),
		.box_h (h_c),
		.org_x (ox_c),
		.org_y (oy_c)
	);

	// oriented box register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && last_s1 && adv2) begin
			rot_s2 <= rot_c;
			w_s2   <= w_c;
			h_s2   <= h_c;
			ox_s2  <= ox_c;
			oy_s2  <= oy_c;
		end
	end

	obsp_place #(
		.COORD_BITS (C),
		.CURSOR_BITS(K)
	) u_place (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.limit  (limit_q),
		.box_w  (w_s2),
		.box_h  (h_s2),
		.org_x  (ox_s2),
		.org_y  (oy_s2),
		.shift_x(sx_c),
		.shift_y(sy_c),
		.side   (side_c)
	);

	assign prod = w_s2 * h_s2;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			shift_x_q <= sx_c;
			shift_y_q <= sy_c;
			rot_q     <= rot_s2;
			w_q       <= w_s2;
			h_q       <= h_s2;
			area_q    <= prod[AW-1:0];
			side_q    <= side_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign shift_x     = shift_x_q;
	assign shift_y     = shift_y_q;
	assign rotation    = rot_q;
	assign mirrored    = 1'b0;
	assign box_width   = w_q;
	assign box_height  = h_q;
	assign box_area    = area_q;
	assign square_side = side_q;

	a_area_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (2*BW)'(box_area) == box_width * box_height)
		else $error("box_area differs from box_width times box_height");

	a_orientation: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rotation ? (box_width < box_height) : (box_width <= box_height)))
		else $error("orientation does not match box shape");

	a_side_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> square_side != '0)
		else $error("square_side is zero");

	a_box_held_under_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !adv_out |=> v_s2 && $stable(w_s2) && $stable(h_s2))
		else $error("box register changed while blocked");

endmodule

`default_nettype wire

/* hw/rtl/obsp_extent.sv */
`default_nettype none

module obsp_extent #(
	parameter int COORD_BITS = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         step,
	input  wire logic                         last,
	input  wire logic signed [COORD_BITS-1:0] cell_x,
	input  wire logic signed [COORD_BITS-1:0] cell_y,
	output logic                              rot,
	output logic             [COORD_BITS:0]   box_w,
	output logic             [COORD_BITS:0]   box_h,
	output logic signed      [COORD_BITS:0]   org_x,
	output logic signed      [COORD_BITS:0]   org_y
);

	localparam int C = COORD_BITS;
	localparam logic signed [C-1:0] EXT_HI = {1'b0, {(C-1){1'b1}}};
	localparam logic signed [C-1:0] EXT_LO = {1'b1, {(C-1){1'b0}}};

	logic signed [C-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic signed [C-1:0] min_x, max_x, min_y, max_y;
	logic signed [C:0]   dx, dy;
	logic        [C:0]   ext_w, ext_h;

	// fold the current cell into the running extent
	always_comb begin
		min_x = (cell_x < min_x_q) ? cell_x : min_x_q;
		max_x = (cell_x > max_x_q) ? cell_x : max_x_q;
		min_y = (cell_y < min_y_q) ? cell_y : min_y_q;
		max_y = (cell_y > max_y_q) ? cell_y : max_y_q;
	end

	always_comb begin
		dx    = $signed({max_x[C-1], max_x}) - $signed({min_x[C-1], min_x});
		dy    = $signed({max_y[C-1], max_y}) - $signed({min_y[C-1], min_y});
		ext_w = $unsigned(dx) + {{C{1'b0}}, 1'b1};
		ext_h = $unsigned(dy) + {{C{1'b0}}, 1'b1};
		rot   = ext_h < ext_w;
		if (rot) begin
			box_w = ext_h;
			box_h = ext_w;
			org_x = $signed({min_y[C-1], min_y});
			org_y = -$signed({max_x[C-1], max_x});
		end else begin
			box_w = ext_w;
			box_h = ext_h;
			org_x = $signed({min_x[C-1], min_x});
			org_y = $signed({min_y[C-1], min_y});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= EXT_HI;
			max_x_q <= EXT_LO;
			min_y_q <= EXT_HI;
			max_y_q <= EXT_LO;
		end else if (step) begin
			if (last) begin
				min_x_q <= EXT_HI;
				max_x_q <= EXT_LO;
				min_y_q <= EXT_HI;
				max_y_q <= EXT_LO;
			end else begin
				min_x_q <= min_x;
				max_x_q <= max_x;
				min_y_q <= min_y;
				max_y_q <= max_y;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/obsp_place.sv */
`default_nettype none

module obsp_place #(
	parameter int COORD_BITS  = 12,
	parameter int CURSOR_BITS = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  commit,
	input  wire logic        [obsp_pkg::LIMIT_BITS-1:0] limit,
	input  wire logic        [COORD_BITS:0]            box_w,
	input  wire logic        [COORD_BITS:0]            box_h,
	input  wire logic signed [COORD_BITS:0]            org_x,
	input  wire logic signed [COORD_BITS:0]            org_y,
	output logic signed      [CURSOR_BITS+1:0]         shift_x,
	output logic signed      [CURSOR_BITS+1:0]         shift_y,
	output logic             [CURSOR_BITS-1:0]         side
);

	localparam int K   = CURSOR_BITS;
	localparam int BW  = COORD_BITS + 1;
	localparam int LB  = obsp_pkg::LIMIT_BITS;
	localparam int M1  = (K > BW) ? K : BW;
	localparam int M2  = (M1 > LB) ? M1 : LB;
	localparam int CW  = M2 + 1;
	localparam int TW  = M1 + 2;
	localparam int SHW = K + 2;

	localparam logic [K-1:0]  CUR_MAX   = {K{1'b1}};
	localparam logic [CW-1:0] CUR_MAX_W = {{(CW-K){1'b0}}, {K{1'b1}}};

	logic [K-1:0]  cursor_x_q, cursor_y_q, layout_width_q;
	logic [BW-1:0] row_height_q;

	logic [CW-1:0]        sum_x;
	logic                 wrap;
	logic [K-1:0]         cx1, cy1, cx2, lw2, height, side0;
	logic [BW-1:0]        rh1, rh2;
	logic signed [TW-1:0] tx, ty;

	function automatic logic [K-1:0] sat(input logic [CW-1:0] s);
		logic [K-1:0] r;
		r = (s > CUR_MAX_W) ? CUR_MAX : s[K-1:0];
		return r;
	endfunction

	always_comb begin
		sum_x  = CW'(cursor_x_q) + CW'(box_w);
		wrap   = (sum_x > CW'(limit)) && (cursor_x_q != '0);
		cx1    = wrap ? '0 : cursor_x_q;
		cy1    = wrap ? sat(CW'(cursor_y_q) + CW'(row_height_q)) : cursor_y_q;
		rh1    = wrap ? '0 : row_height_q;
		tx     = $signed(TW'(cx1)) - TW'(org_x);
		ty     = $signed(TW'(cy1)) - TW'(org_y);
		cx2    = sat(CW'(cx1) + CW'(box_w));
		rh2    = (box_h > rh1) ? box_h : rh1;
		lw2    = (cx2 > layout_width_q) ? cx2 : layout_width_q;
		height = sat(CW'(cy1) + CW'(rh2));
		side0  = (lw2 > height) ? lw2 : height;
		side   = (side0 == '0) ? K'(1) : side0;
	end

	assign shift_x = tx[SHW-1:0];
	assign shift_y = ty[SHW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			row_height_q   <= '0;
			layout_width_q <= '0;
		end else if (commit) begin
			cursor_x_q     <= cx2;
			cursor_y_q     <= cy1;
			row_height_q   <= rh2;
			layout_width_q <= lw2;
		end
	end

	a_cursor_y_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> cursor_y_q >= $past(cursor_y_q))
		else $error("cursor_y moved backward");

	a_layout_covers_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		layout_width_q >= cursor_x_q)
		else $error("layout width below cursor_x");

endmodule

`default_nettype wire

/* tb/oriented_box_shelf_placer_tb.sv */
`timescale 1ns / 100ps

module oriented_box_shelf_placer_tb;

	localparam int COORD_BITS  = 12;
	localparam int CURSOR_BITS = 16;
	localparam int CUR_MAX     = (1 << CURSOR_BITS) - 1;

	typedef struct {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic                         last;
	} cell_beat_t;

	typedef struct {
		logic signed [CURSOR_BITS+1:0] shift_x;
		logic signed [CURSOR_BITS+1:0] shift_y;
		logic                          rotation;
		logic                          mirrored;
		logic        [COORD_BITS:0]    box_width;
		logic        [COORD_BITS:0]    box_height;
		logic        [2*COORD_BITS:0]  box_area;
		logic        [CURSOR_BITS-1:0] square_side;
	} placement_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [obsp_pkg::LIMIT_BITS-1:0] row_width_limit = '0;

	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic signed [COORD_BITS-1:0]  cell_x = '0;
	logic signed [COORD_BITS-1:0]  cell_y = '0;
	logic                          last_cell = 1'b0;

	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [CURSOR_BITS+1:0] shift_x;
	logic signed [CURSOR_BITS+1:0] shift_y;
	logic                          rotation;
	logic                          mirrored;
	logic        [COORD_BITS:0]    box_width;
	logic        [COORD_BITS:0]    box_height;
	logic        [2*COORD_BITS:0]  box_area;
	logic        [CURSOR_BITS-1:0] square_side;

	cell_beat_t cell_q[$];
	placement_t placement_q[$];
	int         mismatch_count = 0;
	bit         calm = 1'b0;

	// shelf state tracked alongside the block
	logic [obsp_pkg::LIMIT_BITS-1:0] shelf_limit = obsp_pkg::LIMIT_RESET;
	logic signed [COORD_BITS-1:0]    ext_min_x = 12'sd2047;
	logic signed [COORD_BITS-1:0]    ext_max_x = -12'sd2048;
	logic signed [COORD_BITS-1:0]    ext_min_y = 12'sd2047;
	logic signed [COORD_BITS-1:0]    ext_max_y = -12'sd2048;
	logic [CURSOR_BITS-1:0]          cur_x = '0;
	logic [CURSOR_BITS-1:0]          cur_y = '0;
	logic [COORD_BITS:0]             row_h = '0;
	logic [CURSOR_BITS-1:0]          lay_w = '0;

	oriented_box_shelf_placer #(
		.COORD_BITS (COORD_BITS),
		.CURSOR_BITS(CURSOR_BITS)
	) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.row_width_limit(row_width_limit),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cell_x         (cell_x),
		.cell_y         (cell_y),
		.last_cell      (last_cell),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.shift_x        (shift_x),
		.shift_y        (shift_y),
		.rotation       (rotation),
		.mirrored       (mirrored),
		.box_width      (box_width),
		.box_height     (box_height),
		.box_area       (box_area),
		.square_side    (square_side)
	);

	always #5 clk = ~clk;

	function automatic int sat_cursor(int v);
		return (v > CUR_MAX) ? CUR_MAX : v;
	endfunction

	task automatic place_cell(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
		logic last);
		int         ext_w, ext_h, w, h, min_ox, min_oy, cx, cy, height, side;
		bit         rot;
		placement_t p;
		if (x < ext_min_x) ext_min_x = x;
		if (x > ext_max_x) ext_max_x = x;
		if (y < ext_min_y) ext_min_y = y;
		if (y > ext_max_y) ext_max_y = y;
		if (!last)
			return;
		ext_w = int'(ext_max_x) - int'(ext_min_x) + 1;
		ext_h = int'(ext_max_y) - int'(ext_min_y) + 1;
		rot = ext_h < ext_w;
		if (rot) begin
			w = ext_h;
			h = ext_w;
			min_ox = int'(ext_min_y);
			min_oy = -int'(ext_max_x);
		end else begin
			w = ext_w;
			h = ext_h;
			min_ox = int'(ext_min_x);
			min_oy = int'(ext_min_y);
		end
		cx = int'(cur_x);
		cy = int'(cur_y);
		// next fit: wrap when the box overflows the limit, unless the shelf is still empty
		if (cx + w > int'(shelf_limit) && cx > 0) begin
			cy = sat_cursor(cy + int'(row_h));
			row_h = '0;
			cx = 0;
		end
		p.shift_x = 18'(cx - min_ox);
		p.shift_y = 18'(cy - min_oy);
		cx = sat_cursor(cx + w);
		if (h > int'(row_h)) row_h = 13'(h);
		if (cx > int'(lay_w)) lay_w = 16'(cx);
		cur_x = 16'(cx);
		cur_y = 16'(cy);
		height = sat_cursor(cy + int'(row_h));
		side = (int'(lay_w) > height) ? int'(lay_w) : height;
		if (side == 0) side = 1;
		p.rotation = rot;
		p.mirrored = 1'b0;
		p.box_width = 13'(w);
		p.box_height = 13'(h);
		p.box_area = 25'(w * h);
		p.square_side = 16'(side);
		placement_q.push_back(p);
		ext_min_x = 12'sd2047;
		ext_max_x = -12'sd2048;
		ext_min_y = 12'sd2047;
		ext_max_y = -12'sd2048;
	endtask

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		cell_beat_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cell_x <= '0;
			cell_y <= '0;
			last_cell <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				place_cell(cell_x, cell_y, last_cell);
			if (!in_valid || !in_stall) begin
				if (cell_q.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
					nxt = cell_q.pop_front();
					cell_x <= nxt.x;
					cell_y <= nxt.y;
					last_cell <= nxt.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		placement_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (placement_q.size() == 0) begin
					$error("result beat with no placement pending");
					mismatch_count++;
				end else begin
					want = placement_q.pop_front();
					compare_field("shift_x", int'(want.shift_x), int'(shift_x));
					compare_field("shift_y", int'(want.shift_y), int'(shift_y));
					compare_field("rotation", int'(want.rotation), int'(rotation));
					compare_field("mirrored", int'(want.mirrored), int'(mirrored));
					compare_field("box_width", int'(want.box_width), int'(box_width));
					compare_field("box_height", int'(want.box_height), int'(box_height));
					compare_field("box_area", int'(want.box_area), int'(box_area));
					compare_field("square_side", int'(want.square_side), int'(square_side));
				end
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 28);
		end
	end

	task automatic push_cell(int x, int y, bit last);
		cell_beat_t c;
		c.x = x[COORD_BITS-1:0];
		c.y = y[COORD_BITS-1:0];
		c.last = last;
		cell_q.push_back(c);
	endtask

	task automatic add_random(int count, int big_pct);
		int  produced, n, sx, sy, bx, by;
		bit  big;
		produced = 0;
		while (produced < count) begin
			if ($urandom_range(0, 99) < 10) begin
				// stray cell, may or may not close a piece
				push_cell(int'($urandom_range(0, 4095)) - 2048,
					int'($urandom_range(0, 4095)) - 2048, $urandom_range(0, 1));
				produced++;
			end else begin
				n = $urandom_range(1, 6);
				big = $urandom_range(0, 99) < big_pct;
				sx = big ? $urandom_range(0, 4095) : $urandom_range(0, 15);
				sy = big ? $urandom_range(0, 4095) : $urandom_range(0, 15);
				bx = $urandom_range(0, 4095 - sx);
				by = $urandom_range(0, 4095 - sy);
				bx -= 2048;
				by -= 2048;
				for (int i = 0; i < n; i++)
					push_cell(bx + int'($urandom_range(0, sx)), by + int'($urandom_range(0, sy)),
						i == n - 1);
				produced += n;
			end
		end
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (cell_q.size() != 0 || in_valid || placement_q.size() != 0);
	endtask

	task automatic write_limit(logic [obsp_pkg::LIMIT_BITS-1:0] v);
		wait_idle();
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		row_width_limit <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		shelf_limit = v;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed beats at the reset limit
		push_cell(0, 0, 1);
		push_cell(-2048, -2048, 1);
		push_cell(2047, 2047, 1);
		push_cell(-2048, 0, 0);
		push_cell(2047, 0, 1);
		push_cell(0, -2048, 0);
		push_cell(0, 2047, 1);
		push_cell(-2048, -2048, 0);
		push_cell(2047, 2047, 1);
		push_cell(-2048, 2047, 0);
		push_cell(2047, -2048, 1);
		push_cell(5, 5, 0);
		push_cell(8, 5, 0);
		push_cell(6, 7, 1);
		push_cell(-3, -3, 0);
		push_cell(0, 0, 0);
		push_cell(-1, -2, 1);
		push_cell(2047, -2048, 0);
		push_cell(2046, -2047, 1);
		push_cell(-2048, 100, 0);
		push_cell(-2047, 100, 1);

		write_limit(16'hFFFF);
		add_random(350, 3);

		write_limit(16'($urandom_range(16, 400)));
		add_random(350, 2);

		// no idling on either side through the zero limit
		write_limit(16'd0);
		calm = 1'b1;
		add_random(150, 0);
		wait_idle();
		calm = 1'b0;

		// tall boxes on single-box shelves push cursor_y toward saturation
		write_limit(16'd1);
		add_random(200, 30);

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
